// File: design/mts_pkg.sv
package mts_pkg;

  localparam int unsigned Depth  = 256;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned EntryW = 9;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FILL = 1'b1
  } state_e;

  typedef struct packed {
    op_e                      opcode;
    logic signed [DataW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0]  top_value;
    logic signed [DataW-1:0]  min_value;
    logic [EntryW-1:0]        entry_count;
    logic                     is_empty;
    status_e                  status;
  } rsp_t;

endpackage

// File: design/mts_ram.sv
module mts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/min_tracking_stack.sv
// Bounded stack of signed 32-bit values that also reports its smallest entry.
//
// Command channel: drive req_i (opcode, value) and raise start; the
// transaction is taken at a rising edge with start high and busy low.
// Result channel: every transaction yields one result on rsp_o, present for
// exactly one cycle while rsp_strobe_o is high. The receiver cannot hold it
// off, so capture it in that cycle.
//
// Timing: a push, a rejected push and a pop on an empty stack report in the
// cycle after acceptance; busy stays low, so a new command may follow in the
// very next cycle. A pop that removes an entry reports after the S_FILL state
// and keeps busy high in S_FILL, where no new command is taken: the new top
// values come out of the data and minimum RAMs, whose read port is
// registered.
//
// Reset clears both counts; the RAM contents stay as they are and need no
// clearing pass, since only entries below the counts are ever used.
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic rsp_strobe_o
);

  state_e state_q, state_d;

  logic [CountW-1:0]       dcnt_q, dcnt_d;
  logic [CountW-1:0]       mcnt_q, mcnt_d;
  logic signed [DataW-1:0] dtop_q, dtop_d;
  logic signed [DataW-1:0] mtop_q, mtop_d;
  logic                    min_pop_q, min_pop_d;
  rsp_t                    rsp_q, rsp_d;
  logic                    strobe_q, strobe_d;

  logic                    accept;
  logic                    emit;
  status_e                 stat;

  logic                    d_we, m_we;
  logic [AddrW-1:0]        d_waddr, m_waddr, d_raddr, m_raddr;
  logic [DataW-1:0]        d_rdata, m_rdata;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Write at the current count; read the entry below the one being popped.
  assign d_waddr = AddrW'(dcnt_q);
  assign m_waddr = AddrW'(mcnt_q);
  assign d_raddr = AddrW'(dcnt_q - CountW'(2));
  assign m_raddr = AddrW'(mcnt_q - CountW'(2));

  mts_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(req_i.value),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  mts_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_min_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(req_i.value),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  // Next state: only a pop that removes an entry waits for the RAM read.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && req_i.opcode == OP_POP && dcnt_q != '0) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath: update counts and cached tops, write RAMs, build the result.
  always_comb begin
    dcnt_d    = dcnt_q;
    mcnt_d    = mcnt_q;
    dtop_d    = dtop_q;
    mtop_d    = mtop_q;
    min_pop_d = min_pop_q;
    d_we      = 1'b0;
    m_we      = 1'b0;
    emit      = 1'b0;
    stat      = STAT_DONE;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.opcode == OP_PUSH) begin
            emit = 1'b1;
            if (dcnt_q == CountW'(Depth)) begin
              stat = STAT_FULL;
            end else begin
              d_we   = 1'b1;
              dcnt_d = dcnt_q + CountW'(1);
              dtop_d = req_i.value;
              // Track a new minimum when none is held or it is no greater than the current one.
              if (mcnt_q == '0 || req_i.value <= mtop_q) begin
                m_we   = 1'b1;
                mcnt_d = mcnt_q + CountW'(1);
                mtop_d = req_i.value;
              end
            end
          end else if (dcnt_q == '0) begin
            emit = 1'b1;
            stat = STAT_EMPTY;
          end else begin
            dcnt_d    = dcnt_q - CountW'(1);
            min_pop_d = (mcnt_q != '0) && (mtop_q == dtop_q);
            if (min_pop_d) begin
              mcnt_d = mcnt_q - CountW'(1);
            end
          end
        end
      end
      S_FILL: begin
        // Load the exposed entries from the RAM read ports.
        emit   = 1'b1;
        dtop_d = d_rdata;
        if (min_pop_q) begin
          mtop_d = m_rdata;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    strobe_d          = emit;
    rsp_d             = rsp_q;
    rsp_d.top_value   = (dcnt_d != '0) ? dtop_d : '0;
    rsp_d.min_value   = (mcnt_d != '0) ? mtop_d : '0;
    rsp_d.entry_count = EntryW'(dcnt_d);
    rsp_d.is_empty    = (dcnt_d == '0);
    rsp_d.status      = stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dcnt_q    <= '0;
      mcnt_q    <= '0;
      min_pop_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      dcnt_q    <= dcnt_d;
      mcnt_q    <= mcnt_d;
      min_pop_q <= min_pop_d;
      strobe_q  <= strobe_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    dtop_q <= dtop_d;
    mtop_q <= mtop_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_o        = rsp_q;
  assign rsp_strobe_o = strobe_q;

`ifndef ASSERT_OFF
  a_min_not_deeper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= dcnt_q)
    else $error("minimum stack deeper than data stack");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= CountW'(Depth))
    else $error("data count beyond depth");

  a_fill_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |=> rsp_strobe_o && !busy)
    else $error("pop result not delivered after RAM read");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.opcode == OP_PUSH && dcnt_q != CountW'(Depth)
    |=> dcnt_q == $past(dcnt_q) + CountW'(1))
    else $error("accepted push did not grow the stack");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o |-> rsp_o.is_empty == (dcnt_q == '0))
    else $error("empty flag disagrees with count");
`endif

endmodule
